[rtl/hmcd_pkg.sv]
// Shared constants, types and helpers of the HTTP message completion detector.
`default_nettype none

package hmcd_pkg;

    // Width of the internal length value and body counter.
    localparam int LENGTH_BITS = 32;
    // Width of the reported length and body count.
    localparam int OUT_BITS    = 32;
    // Width used to clamp an internal value to the reported width.
    localparam int WIDE_BITS   = 64;

    // Field name that carries the body length.
    localparam int NAME_LEN = 14;
    localparam int POS_BITS = $clog2(NAME_LEN);
    localparam logic [7:0] FIELD_NAME [NAME_LEN] = '{
        "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
    };

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Depth of the queue between classifier and tracker.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Largest internal length or count.
    localparam logic [LENGTH_BITS-1:0] SAT_MAX = '1;

    // Progress of the length field parser.
    typedef enum logic [5:0] {
        PH_SEARCH  = 6'b000001,
        PH_WAIT    = 6'b000010,
        PH_SKIP    = 6'b000100,
        PH_DIGITS  = 6'b001000,
        PH_IGNORE  = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    // One classified byte as it travels from the classifier to the tracker.
    typedef struct packed {
        logic                first;
        logic                is_cr;
        logic                is_lf;
        logic                is_colon;
        logic                is_digit;
        logic [3:0]          digit;
        logic                is_blank;
        logic [NAME_LEN-1:0] name_hit;
    } t_beat;

    // Clamp an internal value to the reported width.
    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [LENGTH_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        if (w > WIDE_BITS'({OUT_BITS{1'b1}})) begin
            return '1;
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/hmcd_in_if.sv]
// Input channel: one request byte per beat.
`default_nettype none

interface hmcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

[rtl/hmcd_out_if.sv]
// Output channel: one status beat per accepted byte.
`default_nettype none

interface hmcd_out_if import hmcd_pkg::*; ;
    logic                valid;
    logic                ready;
    logic                complete;
    logic                header_done;
    logic                has_length;
    logic [OUT_BITS-1:0] content_length;
    logic [OUT_BITS-1:0] body_bytes;

    modport source (output valid, output complete, output header_done, output has_length,
                    output content_length, output body_bytes, input ready);
    modport sink   (input valid, input complete, input header_done, input has_length,
                    input content_length, input body_bytes, output ready);
endinterface

`default_nettype wire

[rtl/hmcd_front.sv]
// Front end: takes request bytes and classifies each one for the tracker.
`default_nettype none

module hmcd_front import hmcd_pkg::*; (
    hmcd_in_if.sink i_in,
    output logic    o_push_valid,
    input  logic    i_push_ready,
    output t_beat   o_push_beat
);

    // The queue decides when a byte can be taken.
    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    // Classify the byte: line breaks, separators, digits and name characters.
    always_comb begin
        o_push_beat.first    = i_in.first_byte;
        o_push_beat.is_cr    = (i_in.data_byte == CH_CR);
        o_push_beat.is_lf    = (i_in.data_byte == CH_LF);
        o_push_beat.is_colon = (i_in.data_byte == CH_COLON);
        o_push_beat.is_digit = (i_in.data_byte >= CH_ZERO) && (i_in.data_byte <= CH_NINE);
        o_push_beat.digit    = 4'(i_in.data_byte - CH_ZERO);
        o_push_beat.is_blank = (i_in.data_byte == CH_SPACE) || (i_in.data_byte == CH_TAB);
        for (int k = 0; k < NAME_LEN; k++) begin
            o_push_beat.name_hit[k] = (i_in.data_byte == FIELD_NAME[k]);
        end
    end

endmodule

`default_nettype wire

[rtl/hmcd_queue.sv]
// Short queue of classified bytes between the front end and the tracker.
`default_nettype none

module hmcd_queue import hmcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_beat i_push_beat,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_beat o_pop_beat
);

    t_beat                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic                 push;
    logic                 pop;

    // Handshakes on both sides.
    assign o_push_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_beat   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer wrap.
    always_comb begin
        n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage of queued beats.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_beat;
        end
    end

endmodule

`default_nettype wire

[rtl/hmcd_back.sv]
// Back end: tracks header lines, the length field and the body, and registers the status.
`default_nettype none

module hmcd_back import hmcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_beat_valid,
    output logic        o_beat_ready,
    input  t_beat       i_beat,
    hmcd_out_if.source  o_out
);

    logic                   r_line_start;
    logic                   r_cr_first;
    logic                   r_hdr_end;
    logic [POS_BITS-1:0]    r_pos;
    t_phase                 r_phase;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_body;

    logic                   c_line_start;
    logic                   c_cr_first;
    logic                   c_hdr_end;
    logic [POS_BITS-1:0]    c_pos;
    t_phase                 c_phase;
    logic [LENGTH_BITS-1:0] c_len;
    logic [LENGTH_BITS-1:0] c_body;

    logic                   n_line_start;
    logic                   n_cr_first;
    logic                   n_hdr_end;
    logic [POS_BITS-1:0]    n_pos;
    t_phase                 n_phase;
    logic [LENGTH_BITS-1:0] n_len;
    logic [LENGTH_BITS-1:0] n_body;
    logic                   n_has_len;
    logic                   n_complete;

    logic [LENGTH_BITS+3:0] acc;
    logic                   r_out_valid;
    logic                   pop;

    // A beat is taken when the output register is free or being emptied.
    assign o_beat_ready = !r_out_valid || o_out.ready;
    assign pop          = i_beat_valid && o_beat_ready;
    assign o_out.valid  = r_out_valid;

    // Start of a new request clears all tracking before the byte is applied.
    always_comb begin
        c_line_start = i_beat.first ? 1'b1      : r_line_start;
        c_cr_first   = i_beat.first ? 1'b0      : r_cr_first;
        c_hdr_end    = i_beat.first ? 1'b0      : r_hdr_end;
        c_pos        = i_beat.first ? '0        : r_pos;
        c_phase      = i_beat.first ? PH_SEARCH : r_phase;
        c_len        = i_beat.first ? '0        : r_len;
        c_body       = i_beat.first ? '0        : r_body;
    end

    // Decimal accumulate: ten times the value plus the digit, overflow seen in the top bits.
    assign acc = ((LENGTH_BITS + 4)'(c_len) << 3) + ((LENGTH_BITS + 4)'(c_len) << 1)
               + (LENGTH_BITS + 4)'(i_beat.digit);

    // Per-byte state update.
    always_comb begin
        n_line_start = c_line_start;
        n_cr_first   = c_cr_first;
        n_hdr_end    = c_hdr_end;
        n_pos        = c_pos;
        n_phase      = c_phase;
        n_len        = c_len;
        n_body       = c_body;

        if (c_hdr_end) begin
            // Body byte: count it, saturating.
            if (c_body != SAT_MAX) begin
                n_body = c_body + 1'b1;
            end
        end else begin
            // Length field parser.
            unique case (c_phase) inside
                PH_SEARCH: begin
                    if (i_beat.name_hit[c_pos]) begin
                        if (c_pos == POS_BITS'(NAME_LEN - 1)) begin
                            n_pos   = '0;
                            n_phase = PH_WAIT;
                        end else begin
                            n_pos = c_pos + 1'b1;
                        end
                    end else begin
                        n_pos = POS_BITS'(i_beat.name_hit[0]);
                    end
                end
                PH_WAIT: begin
                    if (i_beat.is_colon) begin
                        n_phase = PH_SKIP;
                    end else if (i_beat.is_cr) begin
                        n_phase = PH_SEARCH;
                    end
                end
                PH_SKIP, PH_DIGITS: begin
                    if (i_beat.is_cr) begin
                        n_phase = PH_DONE;
                    end else if (i_beat.is_digit) begin
                        if (acc[LENGTH_BITS+3:LENGTH_BITS] != '0) begin
                            n_len = SAT_MAX;
                        end else begin
                            n_len = acc[LENGTH_BITS-1:0];
                        end
                        n_phase = PH_DIGITS;
                    end else if (c_phase == PH_SKIP && i_beat.is_blank) begin
                        // Leading blanks before the value are skipped.
                        n_phase = PH_SKIP;
                    end else begin
                        n_phase = PH_IGNORE;
                    end
                end
                PH_IGNORE: begin
                    if (i_beat.is_cr) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = c_phase;
                end
            endcase

            // Line tracking: a line that holds only CR LF ends the header section.
            if (i_beat.is_lf) begin
                if (c_cr_first) begin
                    n_hdr_end = 1'b1;
                end
                n_line_start = 1'b1;
                n_cr_first   = 1'b0;
            end else if (c_line_start && i_beat.is_cr) begin
                n_cr_first   = 1'b1;
                n_line_start = 1'b0;
            end else begin
                n_cr_first   = 1'b0;
                n_line_start = 1'b0;
            end
        end

        n_has_len  = (n_phase == PH_DONE);
        n_complete = n_hdr_end && (!n_has_len || (n_body >= n_len));
    end

    // Tracking state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start <= 1'b1;
            r_cr_first   <= 1'b0;
            r_hdr_end    <= 1'b0;
            r_pos        <= '0;
            r_phase      <= PH_SEARCH;
            r_len        <= '0;
            r_body       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_line_start <= n_line_start;
                r_cr_first   <= n_cr_first;
                r_hdr_end    <= n_hdr_end;
                r_pos        <= n_pos;
                r_phase      <= n_phase;
                r_len        <= n_len;
                r_body       <= n_body;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            o_out.complete       <= n_complete;
            o_out.header_done    <= n_hdr_end;
            o_out.has_length     <= n_has_len;
            o_out.content_length <= clamp_out(n_len);
            o_out.body_bytes     <= clamp_out(n_body);
        end
    end

endmodule

`default_nettype wire

[rtl/http_message_completion_detector_core.sv]
// Top level of the HTTP message completion detector: classifier, queue and tracker.
//
//   Channel  Direction  Per beat
//   i_in     in         data_byte (8), first_byte (1)
//   o_out    out        complete, header_done, has_length, content_length (32), body_bytes (32)
//
// One byte per cycle is sustained while the output is taken; a byte's status is registered
// first in the queue and then in the output register, where it can be taken.
// The tracker's state update is the loop that sets that rate.
// Reset is synchronous and active low; it empties the queue and clears all tracking.
// A two-beat queue lets the input keep flowing while the output stalls, until the queue is full.
`default_nettype none

module http_message_completion_detector_core import hmcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmcd_in_if.sink    i_in,
    hmcd_out_if.source o_out
);

    logic  f_valid;
    logic  f_ready;
    t_beat f_beat;
    logic  q_valid;
    logic  q_ready;
    t_beat q_beat;

    // Byte classifier.
    hmcd_front u_front (
        .i_in         (i_in),
        .o_push_valid (f_valid),
        .i_push_ready (f_ready),
        .o_push_beat  (f_beat)
    );

    // Queue between classifier and tracker.
    hmcd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_beat  (f_beat),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_beat   (q_beat)
    );

    // Message tracker with registered status.
    hmcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (q_valid),
        .o_beat_ready (q_ready),
        .i_beat       (q_beat),
        .o_out        (o_out)
    );

`ifndef ASSERT_OFF
    // An empty queue always takes input.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_valid |-> i_in.ready)
        else $error("input stalled with an empty queue");

    // A queued beat reaches a free output register in the next cycle.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_out.valid) |=> o_out.valid)
        else $error("queued beat not moved to a free output");

    // Completion is only reported once the header section has ended.
    a_complete_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.complete) |-> o_out.header_done)
        else $error("complete reported before header end");
`endif

endmodule

`default_nettype wire
